[sv/lsp_pkg.sv]
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types, register codes and color helpers for the LED strip pattern
// generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsp_pkg;

  // Pattern modes as held in the mode register
  typedef enum logic [1:0] {
    MODE_RAINBOW = 2'd0,
    MODE_PULSE   = 2'd1,
    MODE_FADE    = 2'd2,
    MODE_SOLID   = 2'd3
  } pattern_mode_t;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_BASE_COLOR  = 2'd1;
  localparam logic [1:0] REG_PULSE_WIDTH = 2'd2;

  localparam int          CFG_AW           = 4;
  localparam int          COLOR_W          = 15;
  localparam int          CH_W             = 5;
  localparam int          IDX_W            = 7;
  localparam int          IDX_SPAN         = 128;
  localparam int          WHEEL_STEPS      = 96;
  localparam logic [6:0]  WHEEL_LAST       = 7'd96;
  localparam logic [6:0]  FADE_LAST        = 7'd64;
  localparam logic [5:0]  FADE_HALF        = 6'd32;
  localparam logic [4:0]  CH_MAX           = 5'd31;

  localparam pattern_mode_t   MODE_RESET        = MODE_SOLID;
  localparam logic [14:0]     BASE_COLOR_RESET  = 15'h7C00;
  localparam logic [7:0]      PULSE_WIDTH_RESET = 8'd40;

  // Configuration seen by the datapath
  typedef struct packed {
    pattern_mode_t mode;
    logic [14:0]   base_color;
    logic [7:0]    pulse_width;
    logic          mode_wr;      // mode register written this cycle
  } cfg_t;

  // Pack channels as green 14:10, blue 9:5, red 4:0
  function automatic logic [14:0] pack_grb(input logic [4:0] r, input logic [4:0] g,
                                           input logic [4:0] b);
    return {g, b, r};
  endfunction

  // 96-step color wheel: red->green, green->blue, blue->red
  function automatic logic [14:0] wheel_color(input logic [6:0] pos);
    logic [4:0] s;
    logic [14:0] c;
    s = pos[4:0];
    unique case (pos[6:5])
      2'd0:    c = pack_grb(CH_MAX - s, s, 5'd0);
      2'd1:    c = pack_grb(5'd0, CH_MAX - s, s);
      default: c = pack_grb(s, 5'd0, CH_MAX - s);
    endcase
    return c;
  endfunction

  // Scale one channel: c - floor(c*pos/32)
  function automatic logic [4:0] fade_chan(input logic [4:0] c, input logic [5:0] pos);
    logic [10:0] prod;
    prod = 11'(c) * 11'(pos);
    return c - prod[9:5];
  endfunction

  // Fade the base color by a triangular phase
  function automatic logic [14:0] fade_color(input logic [14:0] base, input logic [6:0] phase);
    logic [5:0] k;
    logic [5:0] d;
    logic [5:0] pos;
    k   = {1'b0, phase[4:0]} | {phase[5], 5'd0};
    d   = (k > FADE_HALF) ? (k - FADE_HALF) : (FADE_HALF - k);
    pos = FADE_HALF - d;
    return pack_grb(fade_chan(base[4:0], pos), fade_chan(base[14:10], pos),
                    fade_chan(base[9:5], pos));
  endfunction

endpackage

`default_nettype wire

[sv/led_strip_pattern_generator.sv]
// ----------------------------------------------------------------------------
// led_strip_pattern_generator
// Answers pixel requests with a 15-bit color in rainbow, pulse, fade or solid
// mode; frame counters step after the last pixel of each frame.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  in_*     | slave     | tdata[6:0] pixel_index, tlast frame_last
//  out_*    | master    | tdata[14:0] pixel_color
//  cfg_*    | APB write | 0x0 pattern_mode, 0x4 base_color, 0x8 pulse_width
//
//  One request per cycle sustained while the output is not stalled; a result
//  passes through the request register stage, then the output register.
//  The pulse store RAM takes at most one write per pulse request, at the head.
//  Reset clears the counters, sets all store pixels to black and loads the
//  register defaults; no clearing pass is needed.
//  A stalled output holds its result while one more request waits in stage 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_strip_pattern_generator import lsp_pkg::*; #(
  parameter int PIXEL_COUNT = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,    // [6:0] pixel_index, [7] zero
  input  wire logic              in_tlast,    // frame_last
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [15:0]       out_tdata,   // [14:0] pixel_color, [15] zero
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  localparam int HW  = $clog2(PIXEL_COUNT + 1);
  localparam int CW  = ((HW > IDX_W) ? HW : IDX_W) + 1;

  cfg_t             cfg;
  logic             accept;
  logic [IDX_W-1:0] idx;
  logic [HW-1:0]    head;
  logic [6:0]       wheel;
  logic [6:0]       fade;
  logic [14:0]      st_color;
  logic             in_range;
  logic [6:0]       wheel_off [IDX_SPAN];
  logic [7:0]       wheel_sum;
  logic [6:0]       wheel_pos;
  logic [14:0]      color_a;

  logic             s1_v_r, s1_v_nxt;
  logic             s1_pulse_r;
  logic [14:0]      s1_color_r;
  logic             s1_go;
  logic [14:0]      s1_final;
  logic             out_v_r, out_v_nxt;
  logic [14:0]      out_data_r;

  assign cfg_pready = 1'b1;
  assign idx        = in_tdata[IDX_W-1:0];
  assign accept     = in_tvalid && in_tready;

  lsp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  lsp_frame_counters #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .HW          (HW)
  ) u_cnt (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .frame_done (accept && in_tlast),
    .head       (head),
    .wheel      (wheel),
    .fade       (fade)
  );

  lsp_pulse_store #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .HW          (HW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .head     (head),
    .accept   (accept),
    .idx      (idx),
    .rd_color (st_color)
  );

  // Wheel offset of each pixel along the strip, fixed at elaboration
  for (genvar i = 0; i < IDX_SPAN; i++) begin : g_wheel
    localparam int WOFF = (i * WHEEL_STEPS) / PIXEL_COUNT;
    assign wheel_off[i] = 7'(WOFF);
  end

  assign in_range  = CW'(idx) < CW'(PIXEL_COUNT);
  assign wheel_sum = 8'(wheel_off[idx]) + 8'(wheel);
  assign wheel_pos = (wheel_sum >= 8'(WHEEL_STEPS)) ? 7'(wheel_sum - 8'(WHEEL_STEPS))
                                                    : wheel_sum[6:0];

  // Color for the non-pulse modes; pulse comes from the store next cycle
  always_comb begin
    color_a = '0;
    if (in_range) begin
      unique case (cfg.mode)
        MODE_RAINBOW: color_a = wheel_color(wheel_pos);
        MODE_FADE:    color_a = fade_color(cfg.base_color, fade);
        MODE_SOLID:   color_a = cfg.base_color;
        default:      color_a = '0;
      endcase
    end
  end

  // Two-stage handshake: stage 1 advances when the output register frees
  assign s1_go     = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_go;
  assign s1_final  = s1_pulse_r ? st_color : s1_color_r;

  always_comb begin
    s1_v_nxt  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
    out_v_nxt = s1_go ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pulse_r <= in_range && (cfg.mode == MODE_PULSE);
      s1_color_r <= color_a;
    end
    if (s1_go) begin
      out_data_r <= s1_final;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_data_r};

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |=> s1_v_r && $stable(s1_color_r) && $stable(s1_pulse_r))
    else $error("stage 1 request lost or changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_v_r || !out_v_r) |-> in_tready)
    else $error("input stalled while a stage is free");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_v_r && (out_data_r == $past(s1_final)))
    else $error("output register did not take stage 1 result");

endmodule

`default_nettype wire

[sv/lsp_ram.sv]
// ----------------------------------------------------------------------------
// lsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsp_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/lsp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lsp_cfg_regs
// APB-style register file: pattern mode, base color and pulse width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsp_cfg_regs import lsp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output cfg_t                   cfg
);

  pattern_mode_t mode_r,        mode_nxt;
  logic [14:0]   base_color_r,  base_color_nxt;
  logic [7:0]    pulse_width_r, pulse_width_nxt;
  logic          wr;
  logic [1:0]    reg_idx;

  assign wr      = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Decode writes
  always_comb begin
    mode_nxt        = mode_r;
    base_color_nxt  = base_color_r;
    pulse_width_nxt = pulse_width_r;
    if (wr) begin
      unique case (reg_idx)
        REG_MODE:        mode_nxt        = pattern_mode_t'(pwdata[1:0]);
        REG_BASE_COLOR:  base_color_nxt  = pwdata[14:0];
        REG_PULSE_WIDTH: pulse_width_nxt = pwdata[7:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_RESET;
      base_color_r  <= BASE_COLOR_RESET;
      pulse_width_r <= PULSE_WIDTH_RESET;
    end else begin
      mode_r        <= mode_nxt;
      base_color_r  <= base_color_nxt;
      pulse_width_r <= pulse_width_nxt;
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_MODE:        prdata = {30'd0, mode_r};
      REG_BASE_COLOR:  prdata = {17'd0, base_color_r};
      REG_PULSE_WIDTH: prdata = {24'd0, pulse_width_r};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg.mode        = mode_r;
  assign cfg.base_color  = base_color_r;
  assign cfg.pulse_width = pulse_width_r;
  assign cfg.mode_wr     = wr && (reg_idx == REG_MODE);

endmodule

`default_nettype wire

[sv/lsp_frame_counters.sv]
// ----------------------------------------------------------------------------
// lsp_frame_counters
// Head, wheel and fade counters that step after the last pixel of a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsp_frame_counters import lsp_pkg::*; #(
  parameter int PIXEL_COUNT = 128,
  parameter int HW          = $clog2(PIXEL_COUNT + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cfg_t          cfg,
  input  wire logic          frame_done,
  output logic      [HW-1:0] head,
  output logic      [6:0]    wheel,
  output logic      [6:0]    fade
);

  logic [HW-1:0] head_r,  head_nxt;
  logic [6:0]    wheel_r, wheel_nxt;
  logic [6:0]    fade_r,  fade_nxt;

  // Advance with wrap; a mode write restarts the run
  always_comb begin
    head_nxt  = head_r;
    wheel_nxt = wheel_r;
    fade_nxt  = fade_r;
    priority if (cfg.mode_wr) begin
      head_nxt  = '0;
      wheel_nxt = '0;
      fade_nxt  = '0;
    end else if (frame_done) begin
      head_nxt  = (head_r == HW'(PIXEL_COUNT)) ? '0 : head_r + 1'b1;
      wheel_nxt = (wheel_r == WHEEL_LAST) ? '0 : wheel_r + 1'b1;
      fade_nxt  = (fade_r == FADE_LAST) ? '0 : fade_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      wheel_r <= '0;
      fade_r  <= '0;
    end else begin
      head_r  <= head_nxt;
      wheel_r <= wheel_nxt;
      fade_r  <= fade_nxt;
    end
  end

  assign head  = head_r;
  assign wheel = wheel_r;
  assign fade  = fade_r;

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= HW'(PIXEL_COUNT))
    else $error("head counter past pixel count");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wheel_r <= WHEEL_LAST) && (fade_r <= FADE_LAST))
    else $error("wheel or fade phase out of range");

  a_mode_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.mode_wr |=> (head_r == '0) && (wheel_r == '0) && (fade_r == '0))
    else $error("counters not cleared by mode write");

endmodule

`default_nettype wire

[sv/lsp_pulse_store.sv]
// ----------------------------------------------------------------------------
// lsp_pulse_store
// Pulse pixel store: color RAM written at the head, plus per-pixel black
// flags set at the tail, so one item needs only one RAM write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsp_pulse_store import lsp_pkg::*; #(
  parameter int PIXEL_COUNT = 128,
  parameter int HW          = $clog2(PIXEL_COUNT + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic [HW-1:0]    head,
  input  wire logic             accept,
  input  wire logic [IDX_W-1:0] idx,
  output logic      [14:0]      rd_color
);

  // Only pixels reachable by a request are kept
  localparam int SD  = (PIXEL_COUNT < IDX_SPAN) ? PIXEL_COUNT : IDX_SPAN;
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int TW  = ((HW > 8) ? HW : 8) + 2;

  logic [TW-1:0]  tail_raw;
  logic [TW-1:0]  tail;
  logic           head_ok;
  logic           tail_ok;
  logic           pulse_req;
  logic [SAW-1:0] head_addr;
  logic [SAW-1:0] tail_addr;
  logic [SAW-1:0] rd_addr;
  logic           we;

  logic [SD-1:0]  black_r, black_nxt;
  logic           hit_black_r, hit_black_nxt;
  logic           byp_r;
  logic [14:0]    byp_data_r;
  logic [14:0]    ram_rdata;

  // Tail position, wrapped once
  assign tail_raw  = TW'(head) - TW'(cfg.pulse_width);
  assign tail      = tail_raw[TW-1] ? tail_raw + TW'(PIXEL_COUNT) : tail_raw;
  assign head_ok   = head < HW'(SD);
  assign tail_ok   = !tail[TW-1] && (tail < TW'(SD));
  assign head_addr = head[SAW-1:0];
  assign tail_addr = tail[SAW-1:0];
  assign rd_addr   = idx[SAW-1:0];
  assign pulse_req = accept && (cfg.mode == MODE_PULSE);
  assign we        = pulse_req && head_ok;

  // Black flags: mode write sets all, head clears, tail sets; tail wins
  always_comb begin
    black_nxt = black_r;
    if (cfg.mode_wr) begin
      black_nxt = '1;
    end else if (pulse_req) begin
      if (head_ok) begin
        black_nxt[head_addr] = 1'b0;
      end
      if (tail_ok) begin
        black_nxt[tail_addr] = 1'b1;
      end
    end
  end

  // Flag of the requested pixel after this item's writes
  always_comb begin
    priority if (pulse_req && tail_ok && (tail_addr == rd_addr)) begin
      hit_black_nxt = 1'b1;
    end else if (we && (head_addr == rd_addr)) begin
      hit_black_nxt = 1'b0;
    end else begin
      hit_black_nxt = black_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_r <= '1;
    end else begin
      black_r <= black_nxt;
    end
  end

  // Hold per-item read context alongside the RAM read data
  always_ff @(posedge clk) begin
    if (accept) begin
      hit_black_r <= hit_black_nxt;
      byp_r       <= we && (head_addr == rd_addr);
      byp_data_r  <= cfg.base_color;
    end
  end

  lsp_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (SD),
    .AW    (SAW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (head_addr),
    .wdata (cfg.base_color),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign rd_color = hit_black_r ? '0 : (byp_r ? byp_data_r : ram_rdata);

endmodule

`default_nettype wire

[tb/sv/lsp_color_checker.sv]
// ----------------------------------------------------------------------------
// lsp_color_checker
// Watches the request, result and register channels of the LED strip pattern
// generator, predicts every pixel color from its own copy of the mode, the
// frame counters and the pulse store, and compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsp_color_checker import lsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,     // [6:0] pixel_index, [7] zero
  input  logic              in_tlast,     // frame_last
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [15:0]       out_tdata,    // [14:0] pixel_color, [15] zero
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                pending_count
);

  localparam int PIXELS = 128;

  pattern_mode_t mode_q;
  logic [14:0]   base_q;
  logic [7:0]    width_q;
  logic [7:0]    head_pos;
  logic [6:0]    wheel_pos;
  logic [6:0]    fade_pos;
  logic [14:0]   pulse_store [PIXELS];
  logic [14:0]   color_q [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Color wheel: red to green, green to blue, blue to red
  function automatic logic [14:0] wheel_rgb(input int pos);
    logic [4:0] s;
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    s = 5'(pos % 32);
    case (pos / 32)
      0: begin
        r = 5'd31 - s; g = s; b = 5'd0;
      end
      1: begin
        r = 5'd0; g = 5'd31 - s; b = s;
      end
      default: begin
        r = s; g = 5'd0; b = 5'd31 - s;
      end
    endcase
    return {g, b, r};
  endfunction

  // Scale each channel in place by the triangular fade level
  function automatic logic [14:0] fade_rgb(input logic [14:0] base, input int phase);
    int          k;
    int          d;
    int          lvl;
    int          ch;
    logic [14:0] c;
    k   = phase % 64;
    d   = (k > 32) ? k - 32 : 32 - k;
    lvl = 32 - d;
    for (int i = 0; i < 3; i++) begin
      ch = int'(base[5*i +: 5]);
      c[5*i +: 5] = 5'(ch - (ch * lvl) / 32);
    end
    return c;
  endfunction

  // Clear counters and the pulse store
  task automatic clear_run();
    head_pos  = '0;
    wheel_pos = '0;
    fade_pos  = '0;
    for (int i = 0; i < PIXELS; i++) pulse_store[i] = '0;
  endtask

  always @(posedge clk) begin : track
    int          tail;
    int          idx;
    logic [14:0] color;
    logic [14:0] want;
    if (!rst_n) begin
      mode_q  = MODE_RESET;
      base_q  = BASE_COLOR_RESET;
      width_q = PULSE_WIDTH_RESET;
      clear_run();
      color_q.delete();
    end else begin
      // Apply register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_MODE: begin
            mode_q = pattern_mode_t'(cfg_pwdata[1:0]);
            clear_run();
          end
          REG_BASE_COLOR:  base_q  = cfg_pwdata[14:0];
          REG_PULSE_WIDTH: width_q = cfg_pwdata[7:0];
          default: ;
        endcase
      end

      // Predict the color of each accepted request
      if (in_tvalid && in_tready) begin
        idx = int'(in_tdata[6:0]);
        if (mode_q == MODE_PULSE) begin
          tail = int'(head_pos) - int'(width_q);
          if (tail < 0) tail += PIXELS;
          if (head_pos < PIXELS) pulse_store[head_pos[6:0]] = base_q;
          if (tail >= 0 && tail < PIXELS) pulse_store[tail] = '0;
        end
        color = '0;
        if (idx < PIXELS) begin
          case (mode_q)
            MODE_RAINBOW: color = wheel_rgb((idx * 96 / PIXELS + int'(wheel_pos)) % 96);
            MODE_PULSE:   color = pulse_store[idx];
            MODE_FADE:    color = fade_rgb(base_q, int'(fade_pos));
            default:      color = base_q;
          endcase
        end
        color_q.push_back(color);

        // Advance the frame counters after the last pixel
        if (in_tlast) begin
          head_pos  = (head_pos == PIXELS) ? 8'd0 : head_pos + 8'd1;
          wheel_pos = (wheel_pos == WHEEL_LAST) ? 7'd0 : wheel_pos + 7'd1;
          fade_pos  = (fade_pos == FADE_LAST) ? 7'd0 : fade_pos + 7'd1;
        end
      end

      // Compare each delivered color with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (color_q.size() == 0) begin
          $display("%0t: unexpected pixel_color, expected none, actual %h",
                   $time, out_tdata[14:0]);
          fail_count++;
        end else begin
          want = color_q.pop_front();
          if (out_tdata[14:0] !== want) begin
            $display("%0t: pixel_color mismatch, expected %h, actual %h",
                     $time, want, out_tdata[14:0]);
            fail_count++;
          end
        end
      end
    end
    pending_count = color_q.size();
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives the LED strip pattern generator with directed and random pixel
// frames in each mode with varied register values, random gaps and stalls on
// both streams; the checker beside the block predicts and compares colors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lsp_pkg::*;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata    = '0;     // [6:0] pixel_index, [7] zero
  logic              in_tlast    = 1'b0;   // frame_last
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [15:0]       out_tdata;            // [14:0] pixel_color, [15] zero
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int fail_count;
  int pending_count;
  bit in_steady  = 1'b0;
  bit out_steady = 1'b0;

  always #5 clk = ~clk;

  led_strip_pattern_generator dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  lsp_color_checker checker_i (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending_count
  );

  // Send one pixel request after a random gap
  task automatic send_pixel(input logic [6:0] idx, input logic last);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 19) == 0) in_steady = !in_steady;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, idx};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Send a run of consecutive pixels, sometimes scrambled or unterminated
  task automatic send_frame(input int len);
    logic [6:0] idx;
    logic       last;
    idx = 7'($urandom_range(0, 127));
    for (int k = 0; k < len; k++) begin
      last = (k == len - 1) && ($urandom_range(0, 15) != 0);
      if ($urandom_range(0, 7) == 0) last = 1'($urandom_range(0, 1));
      send_pixel(($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) : idx, last);
      idx = idx + 7'd1;
    end
  endtask

  // Drop the request valid and wait until every color has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic cfg_write(input logic [1:0] reg_idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Accept results with random stalls
  initial begin : result_sink
    int stall;
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 19) == 0) out_steady = !out_steady;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : run_limit
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    pattern_mode_t mode;
    int            count;
    int            max_len;
    int            sent;
    int            len;
    logic [14:0]   base;
    logic [7:0]    width;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: solid color
    send_pixel(7'd0, 1'b0);
    send_pixel(7'd127, 1'b1);
    drain();

    // Pulse: head write, tail erase, tail landing on the head
    cfg_write(REG_MODE, {30'd0, MODE_PULSE});
    cfg_write(REG_BASE_COLOR, 32'h7FFF);
    cfg_write(REG_PULSE_WIDTH, 32'd1);
    send_pixel(7'd0, 1'b0);
    send_pixel(7'd127, 1'b1);
    send_pixel(7'd1, 1'b0);
    send_pixel(7'd0, 1'b1);
    drain();
    cfg_write(REG_PULSE_WIDTH, 32'd0);
    send_pixel(7'd2, 1'b1);
    drain();
    cfg_write(REG_PULSE_WIDTH, 32'd128);
    send_pixel(7'd3, 1'b1);
    send_pixel(7'd3, 1'b1);
    drain();

    // Rainbow across the strip and into the next frame
    cfg_write(REG_MODE, {30'd0, MODE_RAINBOW});
    send_pixel(7'd0, 1'b0);
    send_pixel(7'd64, 1'b0);
    send_pixel(7'd127, 1'b1);
    send_pixel(7'd127, 1'b1);
    drain();

    // Fade from full, then solid black
    cfg_write(REG_MODE, {30'd0, MODE_FADE});
    send_pixel(7'd5, 1'b1);
    send_pixel(7'd85, 1'b1);
    send_pixel(7'd42, 1'b1);
    drain();
    cfg_write(REG_MODE, {30'd0, MODE_SOLID});
    cfg_write(REG_BASE_COLOR, 32'h0000);
    send_pixel(7'd127, 1'b1);
    send_pixel(7'd0, 1'b0);
    drain();

    // Random phases: three long ones, each wraps a counter, then short ones
    for (int ph = 0; ph < 13; ph++) begin
      case (ph)
        0: begin
          mode = MODE_RAINBOW; count = 120; max_len = 1;
        end
        1: begin
          mode = MODE_PULSE; count = 180; max_len = 1;
        end
        2: begin
          mode = MODE_FADE; count = 120; max_len = 1;
        end
        default: begin
          mode = pattern_mode_t'(ph % 4); count = 30; max_len = 8;
        end
      endcase
      if (ph % 3 == 0)      base = 15'h7FFF;
      else if (ph % 5 == 2) base = 15'h0000;
      else                  base = 15'($urandom_range(0, 32767));
      if (ph == 1 || ph == 9) width = 8'd128;
      else if (ph == 5)       width = 8'd0;
      else                    width = 8'($urandom_range(0, 128));

      // Keep counters running across some phases by skipping the mode write
      if (ph % 6 != 5) cfg_write(REG_MODE, {30'd0, mode});
      cfg_write(REG_BASE_COLOR, {17'd0, base});
      cfg_write(REG_PULSE_WIDTH, {24'd0, width});

      sent = 0;
      while (sent < count) begin
        len = $urandom_range(1, max_len);
        send_frame(len);
        sent += len;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
sv/lsp_pkg.sv
sv/lsp_ram.sv
sv/lsp_cfg_regs.sv
sv/lsp_frame_counters.sv
sv/lsp_pulse_store.sv
sv/led_strip_pattern_generator.sv
tb/sv/lsp_color_checker.sv
tb/sv/tb.sv
